FILE: rtl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared constants and helpers for the radix digit converter
// Value width, derived counter widths, character codes and the digit map.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 5;
    localparam int CHAR_W     = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 5'd10;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_STORE = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_RD    = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Digits 0-9 map to '0'-'9', digits 10-31 to 'A'-'V'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d >= DIGIT_TEN) begin
            r = CHAR_A + {2'b00, d - DIGIT_TEN};
        end else begin
            r = CHAR_ZERO + {2'b00, d};
        end
        return r;
    endfunction

endpackage

FILE: rtl/integer_to_radix_digits.sv
// Timing: each digit comes from the bit-serial restoring divider (ST_DIV, then
// ST_STORE into the digit memory); each character is then read out (ST_RD, then
// ST_OUT), after a leading minus sign (ST_SIGN) for a negative value in radix 10,
// and output stalls hold the sign and the read-out.
// Throughput: one conversion at a time; a new value is taken only in ST_IDLE. An
// invalid radix gives a lone error request. Reset: synchronous active-low aresetn, radix 10.
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed value to ASCII digits in a configurable radix, MSB first.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
    import itrd_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [RADIX_W-1:0]           cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [CHAR_W-1:0]            m_char_code,
    output logic                         m_last,
    output logic                         m_error
);

    state_t                  state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    neg_reg, neg_next;
    logic [DIGIT_W-1:0]      digit_store [VALUE_BITS];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]       m_char_reg, m_char_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_error_reg, m_error_next;

    logic                    radix_ok;
    logic                    out_free;
    logic [RADIX_W-1:0]      rem_shift;
    logic                    q_bit;
    logic [CNT_W-1:0]        count_inc;
    logic [CNT_W-1:0]        count_dec;
    logic                    do_store;
    logic                    do_read;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;
    assign m_error     = m_error_reg;

    assign radix_ok  = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign out_free  = !m_valid_reg || m_ready;
    assign rem_shift = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign q_bit     = (rem_shift >= radix_reg);
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign do_store  = (state_reg == ST_STORE);
    assign do_read   = (state_reg == ST_RD);

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_error_next = m_error_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!radix_ok) begin
                        // A bad radix answers with one error request and no digits.
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_char_next  = CHAR_NUL;
                            m_last_next  = 1'b1;
                            m_error_next = 1'b1;
                        end else begin
                            state_next = ST_SIGN;
                            neg_next   = 1'b0;
                        end
                    end else begin
                        mag_next   = s_value[VALUE_BITS-1] ? VALUE_BITS'(-s_value)
                                                           : VALUE_BITS'(s_value);
                        neg_next   = s_value[VALUE_BITS-1] && (radix_reg == RADIX_DEC);
                        rem_next   = '0;
                        bit_next   = '0;
                        count_next = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // Quotient bits shift into the magnitude word as its top bits leave.
                rem_next = q_bit ? DIGIT_W'(rem_shift - radix_reg) : rem_shift[DIGIT_W-1:0];
                mag_next = {mag_reg[VALUE_BITS-2:0], q_bit};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == IDX_W'(VALUE_BITS - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                count_next = count_inc;
                rem_next   = '0;
                bit_next   = '0;
                if ((mag_reg == '0) || (count_inc == CNT_W'(VALUE_BITS))) begin
                    state_next = neg_reg ? ST_SIGN : ST_RD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN: begin
                // Also holds a pending error result while the output is busy.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = !radix_ok;
                    m_error_next = !radix_ok;
                    m_char_next  = radix_ok ? CHAR_MINUS : CHAR_NUL;
                    state_next   = radix_ok ? ST_RD : ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(rd_data_reg);
                    m_last_next  = (count_reg == CNT_W'(1));
                    m_error_next = 1'b0;
                    count_next   = count_dec;
                    state_next   = (count_reg == CNT_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            mag_reg     <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mag_reg     <= mag_next;
            count_reg   <= count_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        m_error_reg <= m_error_next;
    end

    always_ff @(posedge aclk) begin
        if (do_store) begin
            digit_store[count_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (do_read) begin
            rd_data_reg <= digit_store[count_dec[IDX_W-1:0]];
        end
    end

`ifndef ASSERT_OFF
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (RADIX_W'(rem_reg) < radix_reg))
        else $error("remainder not below radix during division");

    a_error_is_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_error_reg) |-> (m_last_reg && (m_char_reg == CHAR_NUL)))
        else $error("error result is not a lone final request");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(VALUE_BITS)))
        else $error("digit count beyond the digit store");

    a_emit_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RD) || (state_reg == ST_OUT)) |-> (count_reg != '0))
        else $error("emitting with no stored digit");
`endif

endmodule

FILE: dv/tb_integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits: testbench for the radix digit converter
// Writes a series of radix settings, sends signed values under random sender
// gaps and receiver stalls, and checks every character against a local
// conversion predictor.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits
    import itrd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              err;
    } char_exp_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [RADIX_W-1:0]           cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_value;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [CHAR_W-1:0]            m_char_code;
    logic                         m_last;
    logic                         m_error;

    char_exp_t          pending_chars[$];
    char_exp_t          got_char;
    logic [RADIX_W-1:0] radix_reg;
    int                 char_errors = 0;
    int                 burst_left = 0;
    bit                 no_idling = 1'b0;
    logic [15:0]        ready_pattern = 16'hFFFF;
    int                 pattern_pos = 0;

    integer_to_radix_digits i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last),
        .m_error     (m_error)
    );

    always #10 aclk = ~aclk;

    // Expected characters for one conversion in the current radix.
    function automatic void predict_conversion(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [DIGIT_W-1:0]    digits [VALUE_BITS];
        int                    n;
        char_exp_t             c;
        if (radix_reg < RADIX_MIN || radix_reg > RADIX_MAX) begin
            c.code = CHAR_NUL;
            c.last = 1'b1;
            c.err  = 1'b1;
            pending_chars.push_back(c);
            return;
        end
        // Negating the most negative value wraps to 2^31, which is its true magnitude.
        mag = v[VALUE_BITS-1] ? -v : v;
        n = 0;
        while (mag != 0) begin
            digits[n] = DIGIT_W'(mag % radix_reg);
            n++;
            mag = mag / radix_reg;
        end
        if (n == 0) begin
            digits[0] = '0;
            n = 1;
        end
        c.err = 1'b0;
        if (v[VALUE_BITS-1] && radix_reg == RADIX_DEC) begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            c.code = (digits[i] >= DIGIT_TEN) ? CHAR_W'(CHAR_A + digits[i] - DIGIT_TEN)
                                              : CHAR_W'(CHAR_ZERO + digits[i]);
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        longint                       p;
        int                           r;
        int                           k;
        logic signed [VALUE_BITS-1:0] v;
        r = (radix_reg < RADIX_MIN || radix_reg > RADIX_MAX) ? 10 : radix_reg;
        case ($urandom_range(0, 9))
            4: begin
                v = $urandom_range(0, 3 * r);
                if ($urandom_range(0, 1)) v = -v;
            end
            5: begin
                // Near a power of the radix, where the digit count steps.
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k) if (p * r <= 64'sh7FFF_FFFF) p = p * r;
                v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            7: begin
                v = $urandom_range(0, 65535);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = 0;
        if (!no_idling) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                gap = $urandom_range(1, 9);
            end
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_conversion(v);
    endtask

    // The radix only changes once every pending character has come out.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        radix_reg = r;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [RADIX_W-1:0] r, input int n, input bit quiet);
        write_radix(r);
        no_idling = quiet;
        repeat (n) send_value(pick_value());
        no_idling = 1'b0;
    endtask

    task automatic test_reset_radix();
        send_value('0);
        send_value(-1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(10);
    endtask

    task automatic test_radix_extremes();
        write_radix(RADIX_MIN);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(-1);
        send_value('0);
        write_radix(RADIX_MAX);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(31);
        send_value(35);
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        write_radix(6'd3);
        send_value(32'h8000_0000);
    endtask

    task automatic test_invalid_radix();
        write_radix(6'd0);
        send_value(-5);
        write_radix(6'd1);
        send_value(32'h7FFF_FFFF);
        write_radix(6'd33);
        send_value('0);
        write_radix(6'd63);
        send_value(32'h8000_0000);
    endtask

    task automatic test_random_conversions();
        run_phase(RADIX_MIN, 30, 1'b0);
        run_phase(RADIX_DEC, 40, 1'b0);
        run_phase(6'd16, 40, 1'b0);
        run_phase(RADIX_MAX, 40, 1'b0);
        run_phase(6'd3, 35, 1'b0);
        run_phase(RADIX_W'($urandom_range(33, 63)), 8, 1'b0);
        run_phase(RADIX_DEC, 40, 1'b1);
        run_phase(RADIX_W'($urandom_range(2, 32)), 40, 1'b0);
        run_phase(RADIX_W'($urandom_range(2, 32)), 40, 1'b0);
        run_phase(6'd8, 35, 1'b0);
        run_phase(RADIX_W'($urandom_range(2, 32)), 40, 1'b1);
        run_phase(6'd1, 6, 1'b0);
    endtask

    // Receiver: m_ready follows a 16-bit ready pattern, chosen anew from a few patterns each time it wraps.
    always @(negedge aclk) begin
        if (pattern_pos == 0) begin
            case ($urandom_range(0, 4))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'hAAAA;
                3: ready_pattern = 16'hFF00;
                default: ready_pattern = 16'hFFF0;
            endcase
        end
        m_ready <= no_idling || ready_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 16;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("char_code: no request pending, got %0d", m_char_code);
                char_errors++;
            end else begin
                got_char = pending_chars.pop_front();
                if (m_char_code !== got_char.code) begin
                    $error("char_code: expected %0d, got %0d", got_char.code, m_char_code);
                    char_errors++;
                end
                if (m_last !== got_char.last) begin
                    $error("last: expected %0d, got %0d", got_char.last, m_last);
                    char_errors++;
                end
                if (m_error !== got_char.err) begin
                    $error("error: expected %0d, got %0d", got_char.err, m_error);
                    char_errors++;
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_value   = '0;
        radix_reg = RADIX_RESET;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_radix();
        test_radix_extremes();
        test_invalid_radix();
        test_random_conversions();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        // Leave room for one full radix 2 conversion to show any stray output.
        repeat (1200) @(posedge aclk);
        if (char_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
